// ----- src/lgrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgrs_pkg: shared types and constants for the life row step engine
// Item layouts on both queue sides, the job passed from front to back,
// and default sizes.
// ----------------------------------------------------------------------------
package lgrs_pkg;

    localparam int ROW_WIDTH            = 32;
    localparam int GRID_COLUMNS_DEFAULT = 32;
    localparam int JOB_DEPTH_DEFAULT    = 2;

    // Neighbour count that gives a birth, and the extra count that lets a
    // live cell survive.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [ROW_WIDTH-1:0] row_cells;
        logic                 last_row;
    } t_in_item;

    typedef struct packed {
        logic [ROW_WIDTH-1:0] next_row;
        logic                 frame_done;
    } t_out_item;

    // What the back end must do with one job.
    typedef enum logic [1:0] {
        JOB_MID  = 2'd0,  // one result, frame continues
        JOB_SOLO = 2'd1,  // single-row board: one result that ends the frame
        JOB_TAIL = 2'd2   // bottom row: middle row result, then bottom row result
    } t_job_kind;

    typedef struct packed {
        logic [ROW_WIDTH-1:0] up;
        logic [ROW_WIDTH-1:0] mid;
        logic [ROW_WIDTH-1:0] down;
        t_job_kind            kind;
    } t_job;

endpackage

// ----- src/life_generation_row_step.sv -----
// ----------------------------------------------------------------------------
// life_generation_row_step: one Game of Life generation, one row at a time
// Row-streaming B3/S23 engine on a bounded board with dead borders.
// ----------------------------------------------------------------------------
// Push the current board one row per item, top row first, with last_row set
// on the bottom row. Every row after the first releases the next generation
// of the row above it; the bottom row also releases its own next generation,
// flagged by frame_done, and the engine then starts a fresh board. A single
// row with last_row set is a one-row board and gives one result. Rows are
// taken at one per cycle while full is low; the back end produces one
// result per cycle while its output register is free or being popped, so a
// multi-row board's bottom row occupies the evaluator for both of its
// results. Each row's job is registered in the job queue and its result
// then in the output register, and a two-entry job queue between intake and
// evaluator lets the input keep flowing while a result waits on the output
// register. Columns at or above GRID_COLUMNS are treated as dead and read back as zero.
// ----------------------------------------------------------------------------
module life_generation_row_step #(
    parameter int GRID_COLUMNS = lgrs_pkg::GRID_COLUMNS_DEFAULT,
    parameter int JOB_DEPTH    = lgrs_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lgrs_pkg::t_in_item  i_row_item,
    input  logic                push,
    output logic                full,
    output lgrs_pkg::t_out_item o_result,
    output logic                empty,
    input  logic                pop
);
    import lgrs_pkg::*;

    logic in_accept;
    logic job_push, job_full, job_pop, job_empty;
    t_job job_in, job_out;

    // Accept a row only when the queue has room for the job it may create.
    assign full      = job_full;
    assign in_accept = push && !job_full;

    lgrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_row_item),
        .i_accept   (in_accept),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    lgrs_job_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_job   (job_out)
    );

    // Advance results through the evaluator into the output register.
    lgrs_back #(
        .GRID_COLUMNS (GRID_COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_result)
    );

endmodule

// ----- src/lgrs_front.sv -----
// ----------------------------------------------------------------------------
// lgrs_front: row intake
// Holds the two most recent rows of the frame and turns each accepted row
// into a job for the back end.
// ----------------------------------------------------------------------------
module lgrs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgrs_pkg::t_in_item i_item,
    input  logic              i_accept,
    output logic              o_job_push,
    output lgrs_pkg::t_job    o_job
);
    import lgrs_pkg::*;

    logic [ROW_WIDTH-1:0] r_row_above, n_row_above;
    logic [ROW_WIDTH-1:0] r_row_middle, n_row_middle;
    logic                 r_have_row, n_have_row;

    always_comb begin
        n_row_above  = r_row_above;
        n_row_middle = r_row_middle;
        n_have_row   = r_have_row;
        o_job_push   = 1'b0;
        o_job.up     = r_row_above;
        o_job.mid    = r_row_middle;
        o_job.down   = i_item.row_cells;
        o_job.kind   = i_item.last_row ? JOB_TAIL : JOB_MID;
        if (i_accept) begin
            if (!r_have_row) begin
                // first row of a frame
                o_job.up   = '0;
                o_job.mid  = i_item.row_cells;
                o_job.down = '0;
                o_job.kind = JOB_SOLO;
                o_job_push = i_item.last_row;
                if (!i_item.last_row) begin
                    n_row_above  = '0;
                    n_row_middle = i_item.row_cells;
                    n_have_row   = 1'b1;
                end
            end else begin
                o_job_push = 1'b1;
                if (i_item.last_row) begin
                    // end of frame: drop all rows
                    n_row_above  = '0;
                    n_row_middle = '0;
                    n_have_row   = 1'b0;
                end else begin
                    n_row_above  = r_row_middle;
                    n_row_middle = i_item.row_cells;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_above  <= '0;
            r_row_middle <= '0;
            r_have_row   <= 1'b0;
        end else begin
            r_row_above  <= n_row_above;
            r_row_middle <= n_row_middle;
            r_have_row   <= n_have_row;
        end
    end

endmodule

// ----- src/lgrs_job_queue.sv -----
// ----------------------------------------------------------------------------
// lgrs_job_queue: job queue between front and back
// Small register FIFO; lets intake and evaluation stall independently.
// ----------------------------------------------------------------------------
module lgrs_job_queue #(
    parameter int DEPTH = lgrs_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lgrs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lgrs_pkg::t_job o_job
);
    import lgrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- src/lgrs_back.sv -----
// ----------------------------------------------------------------------------
// lgrs_back: generation evaluator
// Applies the B3/S23 rule to one row per cycle while the output register
// is free or being taken, and holds each result there until it is taken.
// ----------------------------------------------------------------------------
module lgrs_back #(
    parameter int GRID_COLUMNS = lgrs_pkg::GRID_COLUMNS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    input  lgrs_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output lgrs_pkg::t_out_item o_item
);
    import lgrs_pkg::*;

    localparam logic [ROW_WIDTH-1:0] COL_MASK = (GRID_COLUMNS >= ROW_WIDTH) ? '1 :
        ROW_WIDTH'((64'd1 << GRID_COLUMNS) - 64'd1);

    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;
    logic                 r_phase, n_phase;
    logic                 can_load, work;
    logic                 second;
    logic [ROW_WIDTH-1:0] op_up, op_mid, op_down, evolved;
    logic [ROW_WIDTH+1:0] pad_up, pad_mid, pad_down;
    logic [3:0]           count;

    assign can_load = !r_out_valid || i_pop;
    assign work     = !i_job_empty && can_load;
    assign second   = (i_job.kind == JOB_TAIL) && r_phase;

    // Bottom row of a tail job is evaluated with a dead row below.
    always_comb begin
        if (second) begin
            op_up   = i_job.mid;
            op_mid  = i_job.down;
            op_down = '0;
        end else begin
            op_up   = i_job.up;
            op_mid  = i_job.mid;
            op_down = i_job.down;
        end
        pad_up   = {1'b0, op_up & COL_MASK, 1'b0};
        pad_mid  = {1'b0, op_mid & COL_MASK, 1'b0};
        pad_down = {1'b0, op_down & COL_MASK, 1'b0};
    end

    always_comb begin
        evolved = '0;
        count   = '0;
        for (int k = 0; k < ROW_WIDTH; k++) begin
            count = 4'(pad_up[k]) + 4'(pad_up[k+1]) + 4'(pad_up[k+2])
                  + 4'(pad_mid[k]) + 4'(pad_mid[k+2])
                  + 4'(pad_down[k]) + 4'(pad_down[k+1]) + 4'(pad_down[k+2]);
            evolved[k] = (count == BIRTH_COUNT) ||
                         (pad_mid[k+1] && (count == SURVIVE_COUNT));
        end
        evolved = evolved & COL_MASK;
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        n_phase     = r_phase;
        o_job_pop   = 1'b0;
        if (work) begin
            n_out_valid      = 1'b1;
            n_out.next_row   = evolved;
            n_out.frame_done = (i_job.kind == JOB_SOLO) || second;
            if ((i_job.kind == JOB_TAIL) && !r_phase) begin
                n_phase = 1'b1;
            end else begin
                n_phase   = 1'b0;
                o_job_pop = 1'b1;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
        end
    end

endmodule
